// ----- rtl/assert_macros.svh -----
// assertion macros shared by the lexer rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define CLX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer assertion failed");

// implication checked in the next cycle
`define CLX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

`endif

// ----- rtl/clx_pkg.sv -----
// types, codes and keyword table of the c subset lexer
// no dependencies
package clx_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_MINUS, MODE_SLASH,
      MODE_LT, MODE_GT, MODE_EQ, MODE_BANG, MODE_LINE, MODE_BLOCK, MODE_STAR
   } mode_type;

   localparam logic [2:0] CLS_END   = 3'd0;
   localparam logic [2:0] CLS_KW    = 3'd1;
   localparam logic [2:0] CLS_ID    = 3'd2;
   localparam logic [2:0] CLS_INT   = 3'd3;
   localparam logic [2:0] CLS_REAL  = 3'd4;
   localparam logic [2:0] CLS_OP    = 3'd5;
   localparam logic [2:0] CLS_ERR   = 3'd6;

   localparam logic [4:0] OP_PLUS   = 5'd0;
   localparam logic [4:0] OP_MINUS  = 5'd1;
   localparam logic [4:0] OP_STAR   = 5'd2;
   localparam logic [4:0] OP_SLASH  = 5'd3;
   localparam logic [4:0] OP_COLON  = 5'd4;
   localparam logic [4:0] OP_ASSIGN = 5'd5;
   localparam logic [4:0] OP_LT     = 5'd6;
   localparam logic [4:0] OP_NE     = 5'd7;
   localparam logic [4:0] OP_LE     = 5'd8;
   localparam logic [4:0] OP_GT     = 5'd9;
   localparam logic [4:0] OP_GE     = 5'd10;
   localparam logic [4:0] OP_EQ     = 5'd11;
   localparam logic [4:0] OP_NOT    = 5'd12;
   localparam logic [4:0] OP_SEMI   = 5'd13;
   localparam logic [4:0] OP_COMMA  = 5'd14;
   localparam logic [4:0] OP_LBRACE = 5'd15;
   localparam logic [4:0] OP_RBRACE = 5'd16;
   localparam logic [4:0] OP_LPAREN = 5'd17;
   localparam logic [4:0] OP_RPAREN = 5'd18;
   localparam logic [4:0] OP_LBRACK = 5'd19;
   localparam logic [4:0] OP_RBRACK = 5'd20;
   localparam logic [4:0] OP_HASH   = 5'd21;
   localparam logic [4:0] OP_QUOTE  = 5'd22;
   localparam logic [4:0] OP_DOT    = 5'd23;
   localparam logic [4:0] OP_PCT    = 5'd24;
   localparam logic [4:0] OP_AMP    = 5'd25;
   localparam logic [4:0] OP_BAR    = 5'd26;

   localparam int          MAX_IDENT_LEN = 8;
   localparam int          KEYWORD_COUNT = 17;
   localparam logic [31:0] NUM_LIMIT     = 32'd2147483647;
   localparam logic [3:0]  FRAC_LIMIT    = 4'd10;

   typedef struct packed {
      logic [2:0]  token_class;
      logic [4:0]  keyword_index;
      logic [4:0]  op_code;
      logic [63:0] ident_text;
      logic [3:0]  ident_length;
      logic [31:0] number_value;
      logic [3:0]  frac_digits;
      logic [15:0] line_number;
      logic        last;
   } tok_type;

   // words are right aligned, first character in the highest used byte
   localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
      64'("main"), 64'("return"), 64'("void"), 64'("int"), 64'("double"),
      64'("char"), 64'("bool"), 64'("if"), 64'("else"), 64'("while"),
      64'("for"), 64'("break"), 64'("continue"), 64'("true"), 64'("false"),
      64'("read"), 64'("write")
   };
   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd6, 4'd4, 4'd3, 4'd6, 4'd4, 4'd4, 4'd2, 4'd4, 4'd5,
      4'd3, 4'd5, 4'd8, 4'd4, 4'd5, 4'd4, 4'd5
   };

   // returns {hit, index}; lowest matching entry wins
   function automatic logic [5:0] kw_match(input logic [63:0] text, input logic [3:0] len);
      logic [5:0] res;
      logic       same;
      logic [3:0] pos;
      res = '0;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         same = (KW_LEN[i] == len);
         for (int j = 0; j < MAX_IDENT_LEN; j++) begin
            pos = 4'(KW_LEN[i] - 4'(j + 1));
            if (4'(j) < len && text[8*j +: 8] != KW_TEXT[i][8*pos[2:0] +: 8]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            res = {1'b1, 5'(i)};
         end
      end
      return res;
   endfunction

endpackage

// ----- rtl/clx_ifs.sv -----
// request and response channel interfaces of the lexer
// depends on nothing; fields follow the token layout in clx_pkg
interface clx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;
   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface clx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_class;
   logic [4:0]  keyword_index;
   logic [4:0]  op_code;
   logic [63:0] ident_text;
   logic [3:0]  ident_length;
   logic signed [31:0] number_value;
   logic [3:0]  frac_digits;
   logic [15:0] line_number;
   logic        last;
   modport source (output valid, output token_class, output keyword_index, output op_code,
                   output ident_text, output ident_length, output number_value,
                   output frac_digits, output line_number, output last, input ready);
   modport sink (input valid, input token_class, input keyword_index, input op_code,
                 input ident_text, input ident_length, input number_value,
                 input frac_digits, input line_number, input last, output ready);
endinterface

// ----- rtl/clx_scan.sv -----
// scanner state and token generation, up to two tokens per request byte
// depends on clx_pkg and assert_macros.svh
`include "assert_macros.svh"
module clx_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        in_byte,
   input  logic              end_of_input,
   output logic              tok0_valid,
   output logic              tok1_valid,
   output clx_pkg::tok_type  tok0,
   output clx_pkg::tok_type  tok1
);

   clx_pkg::mode_type mode_ff, mode_in;
   logic [63:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  frac_ff, frac_in;
   logic        neg_ff, neg_in, ovf_ff, ovf_in, pdig_ff, pdig_in;
   logic [15:0] line_ff, line_in;

   logic             is_dig, is_let, redo, ta_v, tb_v;
   logic [3:0]       dval;
   logic [35:0]      mac;
   logic [5:0]       kw;
   clx_pkg::tok_type blank, ta, tb, fl;
   logic             fl_v;

   assign is_dig = (in_byte >= "0") && (in_byte <= "9");
   assign is_let = ((in_byte >= "a") && (in_byte <= "z")) || ((in_byte >= "A") && (in_byte <= "Z"));
   assign dval   = 4'(in_byte - "0");
   assign mac    = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, dval};
   assign kw     = clx_pkg::kw_match(buf_ff, cnt_ff);

   always_comb begin
      blank = '0;
      blank.line_number = line_ff;
   end

   // token held by the current mode
   always_comb begin
      fl   = blank;
      fl_v = 1'b1;
      case (mode_ff)
         clx_pkg::MODE_IDENT: begin
            if (cnt_ff > 4'(clx_pkg::MAX_IDENT_LEN)) begin
               fl.token_class = clx_pkg::CLS_ERR;
            end else if (kw[5]) begin
               fl.token_class   = clx_pkg::CLS_KW;
               fl.keyword_index = kw[4:0];
            end else begin
               fl.token_class  = clx_pkg::CLS_ID;
               fl.ident_text   = buf_ff;
               fl.ident_length = cnt_ff;
            end
         end
         clx_pkg::MODE_INT, clx_pkg::MODE_FRAC: begin
            if (ovf_ff) begin
               fl.token_class = clx_pkg::CLS_ERR;
            end else begin
               fl.number_value = neg_ff ? (32'd0 - acc_ff) : acc_ff;
               if (mode_ff == clx_pkg::MODE_INT) begin
                  fl.token_class = clx_pkg::CLS_INT;
               end else begin
                  fl.token_class = clx_pkg::CLS_REAL;
                  fl.frac_digits = frac_ff;
               end
            end
         end
         clx_pkg::MODE_MINUS: begin fl.token_class = clx_pkg::CLS_OP; fl.op_code = clx_pkg::OP_MINUS; end
         clx_pkg::MODE_SLASH: begin fl.token_class = clx_pkg::CLS_OP; fl.op_code = clx_pkg::OP_SLASH; end
         clx_pkg::MODE_LT: begin fl.token_class = clx_pkg::CLS_OP; fl.op_code = clx_pkg::OP_LT; end
         clx_pkg::MODE_GT: begin fl.token_class = clx_pkg::CLS_OP; fl.op_code = clx_pkg::OP_GT; end
         clx_pkg::MODE_EQ: begin fl.token_class = clx_pkg::CLS_OP; fl.op_code = clx_pkg::OP_ASSIGN; end
         clx_pkg::MODE_BANG: begin fl.token_class = clx_pkg::CLS_OP; fl.op_code = clx_pkg::OP_NOT; end
         default: fl_v = 1'b0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      frac_in = frac_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      line_in = line_ff;
      pdig_in = is_dig;
      redo    = 1'b0;
      ta_v    = 1'b0;
      ta      = blank;
      tb_v    = 1'b0;
      tb      = blank;

      if (end_of_input) begin
         ta_v    = fl_v;
         ta      = fl;
         tb_v    = 1'b1;
         tb.token_class = clx_pkg::CLS_END;
         mode_in = clx_pkg::MODE_IDLE;
         buf_in  = '0;
         cnt_in  = '0;
         acc_in  = '0;
         frac_in = '0;
         neg_in  = 1'b0;
         ovf_in  = 1'b0;
         pdig_in = 1'b0;
         line_in = 16'd1;
      end else begin
         case (mode_ff)
            clx_pkg::MODE_IDENT: begin
               if (is_let || is_dig || in_byte == "_") begin
                  if (cnt_ff < 4'(clx_pkg::MAX_IDENT_LEN)) begin
                     buf_in[8*cnt_ff[2:0] +: 8] = in_byte;
                     cnt_in = cnt_ff + 4'd1;
                  end else begin
                     cnt_in = 4'(clx_pkg::MAX_IDENT_LEN + 1);
                  end
               end else begin
                  redo = 1'b1;
               end
            end
            clx_pkg::MODE_INT: begin
               if (is_dig) begin
                  if (mac > {4'd0, clx_pkg::NUM_LIMIT}) ovf_in = 1'b1;
                  else acc_in = mac[31:0];
               end else if (in_byte == ".") begin
                  mode_in = clx_pkg::MODE_FRAC;
               end else begin
                  redo = 1'b1;
               end
            end
            clx_pkg::MODE_FRAC: begin
               if (is_dig) begin
                  if (frac_ff >= clx_pkg::FRAC_LIMIT) begin
                     ovf_in = 1'b1;
                  end else begin
                     frac_in = frac_ff + 4'd1;
                     if (mac > {4'd0, clx_pkg::NUM_LIMIT}) ovf_in = 1'b1;
                     else acc_in = mac[31:0];
                  end
               end else begin
                  redo = 1'b1;
               end
            end
            clx_pkg::MODE_MINUS: begin
               if (is_dig) begin
                  mode_in = clx_pkg::MODE_INT;
                  acc_in  = {28'd0, dval};
                  frac_in = '0;
                  neg_in  = 1'b1;
                  ovf_in  = 1'b0;
               end else begin
                  redo = 1'b1;
               end
            end
            clx_pkg::MODE_SLASH: begin
               if (in_byte == "/") mode_in = clx_pkg::MODE_LINE;
               else if (in_byte == "*") mode_in = clx_pkg::MODE_BLOCK;
               else redo = 1'b1;
            end
            clx_pkg::MODE_LT, clx_pkg::MODE_GT, clx_pkg::MODE_EQ, clx_pkg::MODE_BANG: begin
               if (in_byte == "=") begin
                  ta_v = 1'b1;
                  ta.token_class = clx_pkg::CLS_OP;
                  case (mode_ff)
                     clx_pkg::MODE_LT: ta.op_code = clx_pkg::OP_LE;
                     clx_pkg::MODE_GT: ta.op_code = clx_pkg::OP_GE;
                     clx_pkg::MODE_EQ: ta.op_code = clx_pkg::OP_EQ;
                     default: ta.op_code = clx_pkg::OP_NE;
                  endcase
                  mode_in = clx_pkg::MODE_IDLE;
               end else begin
                  redo = 1'b1;
               end
            end
            clx_pkg::MODE_LINE: begin
               if (in_byte == "\n") begin
                  if (line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
                  mode_in = clx_pkg::MODE_IDLE;
               end
            end
            clx_pkg::MODE_BLOCK: begin
               if (in_byte == "*") mode_in = clx_pkg::MODE_STAR;
               else if (in_byte == "\n" && line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
            end
            clx_pkg::MODE_STAR: begin
               if (in_byte == "/") begin
                  mode_in = clx_pkg::MODE_IDLE;
               end else if (in_byte == "\n") begin
                  if (line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
                  mode_in = clx_pkg::MODE_BLOCK;
               end else if (in_byte != "*") begin
                  mode_in = clx_pkg::MODE_BLOCK;
               end
            end
            default: redo = 1'b1;
         endcase

         // pending token ends here; emit it and rescan the byte from idle
         if (redo) begin
            ta_v    = fl_v;
            ta      = fl;
            mode_in = clx_pkg::MODE_IDLE;
            if (in_byte == " " || in_byte == "\t") begin
               mode_in = clx_pkg::MODE_IDLE;
            end else if (in_byte == "\n") begin
               if (line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
            end else if (is_let) begin
               mode_in = clx_pkg::MODE_IDENT;
               buf_in  = {56'd0, in_byte};
               cnt_in  = 4'd1;
            end else if (is_dig) begin
               mode_in = clx_pkg::MODE_INT;
               acc_in  = {28'd0, dval};
               frac_in = '0;
               neg_in  = 1'b0;
               ovf_in  = 1'b0;
            end else if (in_byte == "-") begin
               if (pdig_ff) begin
                  tb_v = 1'b1;
                  tb.token_class = clx_pkg::CLS_OP;
                  tb.op_code = clx_pkg::OP_MINUS;
               end else begin
                  mode_in = clx_pkg::MODE_MINUS;
               end
            end else if (in_byte == "/") begin
               mode_in = clx_pkg::MODE_SLASH;
            end else if (in_byte == "<") begin
               mode_in = clx_pkg::MODE_LT;
            end else if (in_byte == ">") begin
               mode_in = clx_pkg::MODE_GT;
            end else if (in_byte == "=") begin
               mode_in = clx_pkg::MODE_EQ;
            end else if (in_byte == "!") begin
               mode_in = clx_pkg::MODE_BANG;
            end else begin
               tb_v = 1'b1;
               tb.token_class = clx_pkg::CLS_OP;
               case (in_byte)
                  "+": tb.op_code = clx_pkg::OP_PLUS;
                  "*": tb.op_code = clx_pkg::OP_STAR;
                  ":": tb.op_code = clx_pkg::OP_COLON;
                  ";": tb.op_code = clx_pkg::OP_SEMI;
                  ",": tb.op_code = clx_pkg::OP_COMMA;
                  "{": tb.op_code = clx_pkg::OP_LBRACE;
                  "}": tb.op_code = clx_pkg::OP_RBRACE;
                  "(": tb.op_code = clx_pkg::OP_LPAREN;
                  ")": tb.op_code = clx_pkg::OP_RPAREN;
                  "[": tb.op_code = clx_pkg::OP_LBRACK;
                  "]": tb.op_code = clx_pkg::OP_RBRACK;
                  "#": tb.op_code = clx_pkg::OP_HASH;
                  "\"": tb.op_code = clx_pkg::OP_QUOTE;
                  ".": tb.op_code = clx_pkg::OP_DOT;
                  "%": tb.op_code = clx_pkg::OP_PCT;
                  "&": tb.op_code = clx_pkg::OP_AMP;
                  "|": tb.op_code = clx_pkg::OP_BAR;
                  default: tb.token_class = clx_pkg::CLS_ERR;
               endcase
            end
         end
      end
   end

   // pack into slots, first token always in slot zero
   always_comb begin
      tok0       = ta_v ? ta : tb;
      tok1       = tb;
      tok0_valid = ta_v || tb_v;
      tok1_valid = ta_v && tb_v;
      if (tok1_valid) tok1.last = 1'b1;
      else tok0.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= clx_pkg::MODE_IDLE;
         buf_ff  <= '0;
         cnt_ff  <= '0;
         acc_ff  <= '0;
         frac_ff <= '0;
         neg_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
         pdig_ff <= 1'b0;
         line_ff <= 16'd1;
      end else if (take) begin
         mode_ff <= mode_in;
         buf_ff  <= buf_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         frac_ff <= frac_in;
         neg_ff  <= neg_in;
         ovf_ff  <= ovf_in;
         pdig_ff <= pdig_in;
         line_ff <= line_in;
      end
   end

   `CLX_ASSERT_NXT(a_eoi_idle, clock, reset, take && end_of_input, mode_ff == clx_pkg::MODE_IDLE && line_ff == 16'd1)
   `CLX_ASSERT_IMP(a_line_nonzero, clock, reset, 1'b1, line_ff != 16'd0)
   `CLX_ASSERT_IMP(a_eoi_ends, clock, reset, end_of_input, tok0_valid && (tok1_valid ? tok1.token_class == clx_pkg::CLS_END : tok0.token_class == clx_pkg::CLS_END))

endmodule

// ----- rtl/clx_rsp_fifo.sv -----
// four entry token queue between scanner and response channel, two writes per cycle
// depends on clx_pkg and assert_macros.svh
`include "assert_macros.svh"
module clx_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push0,
   input  logic              push1,
   input  clx_pkg::tok_type  wdata0,
   input  clx_pkg::tok_type  wdata1,
   output logic              room2,
   output logic              out_valid,
   input  logic              out_pop,
   output clx_pkg::tok_type  rdata
);

   clx_pkg::tok_type mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign room2     = (cnt_ff <= 3'd2);
   assign out_valid = (cnt_ff != 3'd0);
   assign pop       = out_valid && out_pop;
   assign rdata     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + 2'(push0) + 2'(push1);
      rd_in  = rd_ff + 2'(pop);
      cnt_in = cnt_ff + 3'(push0) + 3'(push1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0) mem_ff[wr_ff] <= wdata0;
      if (push1) mem_ff[wr_ff + 2'd1] <= wdata1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `CLX_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 3'd4)
   `CLX_ASSERT_IMP(a_ptr_gap, clock, reset, 1'b1, 2'(wr_ff - rd_ff) == cnt_ff[1:0])
   `CLX_ASSERT_IMP(a_push_room, clock, reset, push1, push0 && cnt_ff <= 3'd2)

endmodule

// ----- rtl/c_subset_lexer.sv -----
// Streaming lexer for a small C subset: one source byte (or an end marker) per
// request, tokens out on the response channel. A request is taken every cycle
// while the four-entry token queue has room for two tokens; the scanner state is
// updated in the same cycle, so the sustained rate is one byte per clock while
// the queue has room; the byte that completes a token writes it into the queue.
// A byte may emit up to two tokens; the final token of each byte has last set.
// Response stalls back up into the request side once three tokens are queued.
// top level; depends on clx_pkg, clx_ifs, clx_scan and clx_rsp_fifo
module c_subset_lexer (
   input logic      clock,
   input logic      reset,
   clx_req_if.sink  req_bus,
   clx_rsp_if.source rsp_bus
);

   logic             take, t0v, t1v, room;
   clx_pkg::tok_type t0, t1, head;

   assign req_bus.ready = room;
   assign take          = req_bus.valid && room;

   clx_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .in_byte      (req_bus.in_byte),
      .end_of_input (req_bus.end_of_input),
      .tok0_valid   (t0v),
      .tok1_valid   (t1v),
      .tok0         (t0),
      .tok1         (t1)
   );

   clx_rsp_fifo u_fifo (
      .clock          (clock),
      .reset          (reset),
      .push0          (take && t0v),
      .push1          (take && t1v),
      .wdata0         (t0),
      .wdata1         (t1),
      .room2          (room),
      .out_valid      (rsp_bus.valid),
      .out_pop        (rsp_bus.ready),
      .rdata          (head)
   );

   assign rsp_bus.token_class   = head.token_class;
   assign rsp_bus.keyword_index = head.keyword_index;
   assign rsp_bus.op_code       = head.op_code;
   assign rsp_bus.ident_text    = head.ident_text;
   assign rsp_bus.ident_length  = head.ident_length;
   assign rsp_bus.number_value  = head.number_value;
   assign rsp_bus.frac_digits   = head.frac_digits;
   assign rsp_bus.line_number   = head.line_number;
   assign rsp_bus.last          = head.last;

endmodule
